/* design/cross_kernel_sharpen_3x3_defines.svh */
// Assertion macros for the sharpen filter.
// Used by files that assert; expect clk and rst_n in scope.
`ifndef CROSS_KERNEL_SHARPEN_3X3_DEFINES_SVH
`define CROSS_KERNEL_SHARPEN_3X3_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CKS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sharpen filter check failed");

// Next-cycle implication, off during reset.
`define CKS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sharpen filter check failed");

`endif

/* design/cks_pkg.sv */
// Shared constants and types for the 3x3 sharpen filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cks_pkg;

  localparam int DATA_W       = 8;
  localparam int CHANNELS     = 4;
  localparam int PIX_W        = DATA_W * 4;
  localparam int MAX_WIDTH    = 4096;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int DIM_MIN      = 3;
  localparam int LANE_SUM_W   = DATA_W + 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-request control carried through the compute stage
  typedef struct packed {
    logic first;     // emits the result for the row above
    logic last_row;  // emits the own-position zero result too
    logic interior;  // window lies fully inside the frame
    logic done;      // last column of the row
  } s1_ctl_t;

  // One queued request: one or two results
  typedef struct packed {
    pix_t pix;
    logic first;
    logic second;
    logic done;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

/* design/cks_lane.sv */
// One channel lane: 5*centre minus the four cross neighbors, clamped.
// Depends on cks_pkg for the data widths.
`timescale 1ns / 1ps
`default_nettype none
module cks_lane (
  input  wire logic [cks_pkg::DATA_W-1:0] centre,
  input  wire logic [cks_pkg::DATA_W-1:0] left_px,
  input  wire logic [cks_pkg::DATA_W-1:0] right_px,
  input  wire logic [cks_pkg::DATA_W-1:0] up_px,
  input  wire logic [cks_pkg::DATA_W-1:0] down_px,
  input  wire logic                       interior,
  output logic      [cks_pkg::DATA_W-1:0] result
);

  localparam int SW = cks_pkg::LANE_SUM_W;
  localparam int DW = cks_pkg::DATA_W;

  logic        [SW-1:0] centre_x5;
  logic        [SW-1:0] neigh_sum;
  logic signed [SW-1:0] diff;

  // Scale centre by five, add up the neighbors
  assign centre_x5 = {{(SW-DW-2){1'b0}}, centre, 2'b00} + {{(SW-DW){1'b0}}, centre};
  assign neigh_sum = {{(SW-DW){1'b0}}, left_px} + {{(SW-DW){1'b0}}, right_px}
                   + {{(SW-DW){1'b0}}, up_px}   + {{(SW-DW){1'b0}}, down_px};
  assign diff      = $signed(centre_x5 - neigh_sum);

  // Clamp to the byte range, zero on the border
  always_comb begin
    if (!interior || diff < 0) begin
      result = '0;
    end else if (diff > $signed(SW'((1 << DW) - 1))) begin
      result = '1;
    end else begin
      result = diff[DW-1:0];
    end
  end

endmodule
`default_nettype wire

/* design/cks_line_store.sv */
// Two row memories holding the previous two rows of packed pixels.
// Depends on cks_pkg; reads are registered, one write per memory per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cks_line_store (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [cks_pkg::ADDR_W-1:0] rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [cks_pkg::ADDR_W-1:0] wr_addr,
  input  wire cks_pkg::pix_t              prior_wdata,
  input  wire cks_pkg::pix_t              older_wdata,
  output cks_pkg::pix_t                   prior_q,
  output cks_pkg::pix_t                   prior_next_q,
  output cks_pkg::pix_t                   older_q
);

  cks_pkg::pix_t prior_mem [cks_pkg::MAX_WIDTH];
  cks_pkg::pix_t older_mem [cks_pkg::MAX_WIDTH];

  logic [cks_pkg::ADDR_W-1:0] rd_addr_next;

  // Right neighbor column; wraps past the end, only read on the border
  assign rd_addr_next = rd_addr + cks_pkg::ADDR_W'(1);

  // Row above: centre and right neighbor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prior_mem[wr_addr] <= prior_wdata;
    end
    if (rd_en) begin
      prior_q      <= prior_mem[rd_addr];
      prior_next_q <= prior_mem[rd_addr_next];
    end
  end

  // Two rows up
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= older_wdata;
    end
    if (rd_en) begin
      older_q <= older_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/cks_out_queue.sv */
// Result queue: one entry per request, unrolled into one or two results.
// Depends on cks_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none
module cks_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cks_pkg::q_entry_t push_entry,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cks_pkg::pix_t          out_pix,
  output logic                   out_last,
  output logic                   out_done,
  output cks_pkg::q_stat_t       stat
);

  localparam int D = cks_pkg::QUEUE_DEPTH;
  localparam int PW = cks_pkg::QPTR_W;
  localparam int CW = cks_pkg::QCNT_W;

  cks_pkg::q_entry_t q_mem_r [D];
  cks_pkg::q_entry_t head;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          phase_r, phase_nxt;
  logic          second_now;
  logic          take;
  logic          pop;

  assign head       = q_mem_r[rd_ptr_r];
  assign out_valid  = (cnt_r != '0);
  assign second_now = phase_r || !head.first;
  assign out_pix    = second_now ? '0 : head.pix;
  assign out_last   = second_now || !head.second;
  assign out_done   = second_now && head.done;
  assign take       = out_valid && out_ready;
  assign pop        = take && out_last;
  assign stat.count = cnt_r;

  // Advance pointers, count and result phase
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
    phase_nxt  = take ? !pop : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* design/cross_kernel_sharpen_3x3.sv */
// Top level of the 3x3 cross-kernel sharpen filter for RGBA streams.
// Depends on cks_pkg, cks_lane, cks_line_store, cks_out_queue and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "cross_kernel_sharpen_3x3_defines.svh"
// Streaming 3x3 sharpen: each channel gets 5*centre minus its left, right, up
// and down neighbors, clamped to 0..255, with border rows and columns forced
// to zero. One pixel is taken per clock while in_ready is high. The result for
// row r-1 is computed once the pixel of row r at the same column arrives; row 0
// gives no results, and each pixel of the last row gives two (the row above,
// then its own zero), so that row is paced by the single result port. An
// accepted pixel loads the registered line-store read and the compute stage
// together; the four combinational channel lanes then feed a four-entry result
// queue. The line stores need no clearing after reset. The user must write
// frame_width and frame_height only while the block is idle; nothing enforces it.
module cross_kernel_sharpen_3x3 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [cks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cks_pkg::CFG_W-1:0]     cfg_wdata,
  // input pixels
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cks_pkg::DATA_W-1:0]    in_chan_red,
  input  wire logic [cks_pkg::DATA_W-1:0]    in_chan_green,
  input  wire logic [cks_pkg::DATA_W-1:0]    in_chan_blue,
  input  wire logic [cks_pkg::DATA_W-1:0]    in_chan_alpha,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [cks_pkg::DATA_W-1:0]    out_red,
  output logic      [cks_pkg::DATA_W-1:0]    out_green,
  output logic      [cks_pkg::DATA_W-1:0]    out_blue,
  output logic      [cks_pkg::DATA_W-1:0]    out_alpha,
  output logic                               out_run_last,
  output logic                               out_frame_done
);

  localparam int DW = cks_pkg::DATA_W;
  localparam int AW = cks_pkg::ADDR_W;
  localparam int RW = cks_pkg::ROW_W;
  localparam int CFW = cks_pkg::CFG_W;
  localparam int CW = cks_pkg::QCNT_W;

  logic [CFW-1:0] frame_width_r, frame_height_r;
  logic [CFW-1:0] width_sat, height_sat;
  logic [AW-1:0]  col_last;
  logic [RW-1:0]  row_last;

  logic [AW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  col_cur;
  logic [RW-1:0]  row_cur;
  logic           in_acc;
  logic           last_row;
  cks_pkg::pix_t  in_pix;
  cks_pkg::s1_ctl_t s0_ctl;

  logic             s1_v_r;
  logic [AW-1:0]    s1_col_r;
  cks_pkg::pix_t    s1_pix_r;
  cks_pkg::s1_ctl_t s1_ctl_r;
  cks_pkg::pix_t    left_r;

  cks_pkg::pix_t     prior_q, prior_next_q, older_q;
  cks_pkg::pix_t     s1_res;
  cks_pkg::pix_t     q_pix;
  cks_pkg::q_entry_t push_entry;
  cks_pkg::q_stat_t  q_stat;
  logic              push;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cks_pkg::FRAME_WIDTH_RST;
      frame_height_r <= cks_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cks_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        cks_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the frame size to its legal range
  always_comb begin
    if (frame_width_r < CFW'(cks_pkg::DIM_MIN)) begin
      width_sat = CFW'(cks_pkg::DIM_MIN);
    end else if (frame_width_r > CFW'(cks_pkg::MAX_WIDTH)) begin
      width_sat = CFW'(cks_pkg::MAX_WIDTH);
    end else begin
      width_sat = frame_width_r;
    end
    if (frame_height_r < CFW'(cks_pkg::DIM_MIN)) begin
      height_sat = CFW'(cks_pkg::DIM_MIN);
    end else if (frame_height_r > CFW'(cks_pkg::HEIGHT_LIMIT)) begin
      height_sat = CFW'(cks_pkg::HEIGHT_LIMIT);
    end else begin
      height_sat = frame_height_r;
    end
  end

  assign col_last = AW'(width_sat - CFW'(1));
  assign row_last = RW'(height_sat - CFW'(1));

  // Position of the incoming pixel, held inside the frame
  assign col_cur  = (col_r > col_last) ? col_last : col_r;
  assign row_cur  = (row_r > row_last) ? row_last : row_r;
  assign last_row = (row_cur == row_last);
  assign in_acc   = in_valid && in_ready;

  // Leave room in the queue for everything in flight
  assign in_ready = ((q_stat.count + CW'(s1_v_r)) < CW'(cks_pkg::QUEUE_DEPTH));

  assign in_pix = {in_chan_alpha, in_chan_blue, in_chan_green, in_chan_red};

  always_comb begin
    s0_ctl.first    = (row_cur != '0);
    s0_ctl.last_row = last_row;
    s0_ctl.interior = (row_cur >= RW'(2)) && (col_cur != '0) && (col_cur < col_last);
    s0_ctl.done     = (col_cur == col_last);
  end

  // Advance the raster counters
  always_comb begin
    if (col_cur == col_last) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + RW'(1);
    end else begin
      col_nxt = col_cur + AW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Compute stage: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  // Compute stage: payload, and the left neighbor from the previous request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_cur;
      s1_pix_r <= in_pix;
      s1_ctl_r <= s0_ctl;
    end
    if (s1_v_r) begin
      left_r <= prior_q;
    end
  end

  cks_line_store u_line_store (
    .clk          (clk),
    .rd_en        (in_acc),
    .rd_addr      (col_cur),
    .wr_en        (s1_v_r),
    .wr_addr      (s1_col_r),
    .prior_wdata  (s1_pix_r),
    .older_wdata  (prior_q),
    .prior_q      (prior_q),
    .prior_next_q (prior_next_q),
    .older_q      (older_q)
  );

  // Channel lanes; merge their bytes into one pixel
  for (genvar ch = 0; ch < 4; ch++) begin : g_lane
    if (ch < cks_pkg::CHANNELS) begin : g_on
      cks_lane u_lane (
        .centre   (prior_q[ch*DW +: DW]),
        .left_px  (left_r[ch*DW +: DW]),
        .right_px (prior_next_q[ch*DW +: DW]),
        .up_px    (older_q[ch*DW +: DW]),
        .down_px  (s1_pix_r[ch*DW +: DW]),
        .interior (s1_ctl_r.interior),
        .result   (s1_res[ch*DW +: DW])
      );
    end else begin : g_off
      assign s1_res[ch*DW +: DW] = '0;
    end
  end

  // Queue every request that produces results
  assign push              = s1_v_r && (s1_ctl_r.first || s1_ctl_r.last_row);
  assign push_entry.pix    = s1_res;
  assign push_entry.first  = s1_ctl_r.first;
  assign push_entry.second = s1_ctl_r.last_row;
  assign push_entry.done   = s1_ctl_r.done;

  cks_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pix    (q_pix),
    .out_last   (out_run_last),
    .out_done   (out_frame_done),
    .stat       (q_stat)
  );

  assign out_red   = q_pix[0*DW +: DW];
  assign out_green = q_pix[1*DW +: DW];
  assign out_blue  = q_pix[2*DW +: DW];
  assign out_alpha = q_pix[3*DW +: DW];

  // Checks
  `CKS_ASSERT_NXT(a_accept_enters_stage, in_acc, s1_v_r)
  `CKS_ASSERT_IMP(a_done_is_last, out_valid && out_frame_done, out_run_last)
  `CKS_ASSERT_IMP(a_write_in_frame, s1_v_r, s1_col_r <= col_last)
  `CKS_ASSERT_IMP(a_border_zero, s1_v_r && !s1_ctl_r.interior, s1_res == '0)

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the cross_kernel_sharpen_3x3 RGBA sharpen filter.
// Depends on cks_pkg and the filter RTL. A scoreboard class carries its own
// line-store predictor; randomized frames are driven on all four channels.

module testbench;
  import cks_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int RST_CYCLES = 6;
  localparam int STALL_MAX  = 4;
  localparam int DRAIN_WAIT = 8;
  localparam int HANG_LIMIT = 2000;
  localparam int RAND_ITEMS = 1000;
  localparam int REPORT_MAX = 10;
  localparam int CFG_MAX    = (1 << CFG_W) - 1;

  // One filtered pixel as it leaves the block
  typedef struct packed {
    logic [DATA_W-1:0] red, green, blue, alpha;
    logic              run_last;
    logic              frame_done;
  } sharp_px_t;

  typedef enum {PH_FRAMES, PH_PARTIAL, PH_WIDE_PART, PH_TALL} phase_kind_t;

  // Predict filtered pixels from accepted requests and check the results
  class sharpen_scoreboard;
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] prior_row [MAX_WIDTH];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      width_reg;
    int unsigned      height_reg;
    sharp_px_t        expected_px [$];
    int               errors;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        prior_row[i] = '0;
      end
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = 32'(FRAME_WIDTH_RST);
      height_reg = 32'(FRAME_HEIGHT_RST);
      errors     = 0;
    endfunction

    function int unsigned sat_dim(int unsigned raw, int unsigned hi);
      if (raw < DIM_MIN) return DIM_MIN;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function int unsigned eff_width();
      return sat_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return sat_dim(height_reg, HEIGHT_LIMIT);
    endfunction

    // Counters left past the frame by a register change act as the last index
    function int unsigned cur_col();
      return (col_cnt > eff_width() - 1) ? eff_width() - 1 : col_cnt;
    endfunction

    function int unsigned cur_row();
      return (row_cnt > eff_height() - 1) ? eff_height() - 1 : row_cnt;
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    // Requests still needed to wrap both counters back to zero
    function int unsigned to_frame_end();
      return (eff_height() - 1 - cur_row()) * eff_width() + (eff_width() - cur_col());
    endfunction

    function int unsigned pending();
      return expected_px.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      if (index == REG_FRAME_WIDTH) width_reg = 32'(value);
      else if (index == REG_FRAME_HEIGHT) height_reg = 32'(value);
    endfunction

    function int lane(logic [PIX_W-1:0] word, int ch);
      return int'(word[8*ch +: 8]);
    endfunction

    function sharp_px_t pack_px(logic [PIX_W-1:0] pix, bit last, bit done);
      return {pix[7:0], pix[15:8], pix[23:16], pix[31:24], last, done};
    endfunction

    function string show(sharp_px_t p);
      return $sformatf("r=%02h g=%02h b=%02h a=%02h last=%0b done=%0b",
                       p.red, p.green, p.blue, p.alpha, p.run_last, p.frame_done);
    endfunction

    // Work out the results of one accepted request, then advance the stores
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned      w, h, c, r;
      bit               last_row;
      logic [PIX_W-1:0] res;
      int               v;
      int               ch;
      w        = eff_width();
      h        = eff_height();
      c        = cur_col();
      r        = cur_row();
      last_row = (r == h - 1);
      if (r >= 1) begin
        res = '0;
        if (r >= 2 && c >= 1 && c + 1 < w) begin
          for (ch = 0; ch < CHANNELS; ch++) begin
            v = 5 * lane(prior_row[c], ch) - lane(older_row[c-1], ch)
              - lane(prior_row[c+1], ch) - lane(older_row[c], ch) - lane(px, ch);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res[8*ch +: 8] = v[7:0];
          end
        end
        expected_px.push_back(pack_px(res, !last_row, 1'b0));
      end
      // Last row also gives the zero result of its own position
      if (last_row) expected_px.push_back(pack_px('0, 1'b1, c == w - 1));
      older_row[c] = prior_row[c];
      prior_row[c] = px;
      if (c == w - 1) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    function void check_result(sharp_px_t got);
      sharp_px_t want;
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_px.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.run_last !== want.run_last ||
          got.frame_done !== want.frame_done) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_chan_red    = '0;
  logic [DATA_W-1:0]    in_chan_green  = '0;
  logic [DATA_W-1:0]    in_chan_blue   = '0;
  logic [DATA_W-1:0]    in_chan_alpha  = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [DATA_W-1:0]    out_red;
  logic [DATA_W-1:0]    out_green;
  logic [DATA_W-1:0]    out_blue;
  logic [DATA_W-1:0]    out_alpha;
  logic                 out_run_last;
  logic                 out_frame_done;

  bit                   send_idle      = 1'b0;
  bit                   recv_idle      = 1'b0;
  int                   quiet_cycles   = 0;
  sharpen_scoreboard    sb;

  always #CLK_HALF clk = ~clk;

  cross_kernel_sharpen_3x3 u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chan_red    (in_chan_red),
    .in_chan_green  (in_chan_green),
    .in_chan_blue   (in_chan_blue),
    .in_chan_alpha  (in_chan_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

  // Pick bytes with the rails favored so clamping hits both ends
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    int               ch;
    for (ch = 0; ch < CHANNELS; ch++) begin
      case ($urandom_range(0, 3))
        0:       px[8*ch +: 8] = 8'h00;
        1:       px[8*ch +: 8] = 8'hFF;
        default: px[8*ch +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  // Mostly legal small sizes, now and then one that saturates up to the minimum
  function automatic logic [CFG_W-1:0] small_dim(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, DIM_MIN - 1));
    return CFG_W'($urandom_range(DIM_MIN, hi));
  endfunction

  // Offer one request after a random gap; hold valid until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_chan_red   <= px[7:0];
    in_chan_green <= px[15:8];
    in_chan_blue  <= px[23:16];
    in_chan_alpha <= px[31:24];
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_run(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Drop valid and wait for the block to drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the selected registers back to back; the predictor follows each edge
  task automatic write_regs(input bit set_w, input logic [CFG_W-1:0] w,
                            input bit set_h, input logic [CFG_W-1:0] h);
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
      sb.set_reg(REG_FRAME_WIDTH, w);
    end
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
      sb.set_reg(REG_FRAME_HEIGHT, h);
    end
    cfg_we <= 1'b0;
  endtask

  // Accept results with random stalls on the ready side
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Record accepted requests, check accepted results, track progress
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_pixel({in_chan_alpha, in_chan_blue, in_chan_green, in_chan_red});
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_red, out_green, out_blue, out_alpha, out_run_last, out_frame_done});
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
  end

  // Stop a run in which nothing moves for too long
  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]       alpha_grid [0:8];
    logic [PIX_W-1:0] px;
    logic [CFG_W-1:0] raw_w;
    logic [CFG_W-1:0] raw_h;
    int unsigned      w, h, n, rand_sent, phase, pick;
    phase_kind_t      kind;
    bit               centre;

    sb = new();
    // Alpha around the center: up 50, left 10, right 70, down 60, center 60
    alpha_grid = '{8'hA5, 8'd50, 8'hA5, 8'd10, 8'd60, 8'd70, 8'hA5, 8'd60, 8'hA5};
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame from sizes below the minimum: red saturates high, green low,
    // blue flat, alpha lands in range
    write_regs(1'b1, '0, 1'b1, 13'd1);
    for (int i = 0; i < 9; i++) begin
      centre = (i == 4);
      px = {alpha_grid[i], 8'h80, centre ? 8'h00 : 8'hFF, centre ? 8'hFF : 8'h00};
      send_pixel(px);
    end
    settle();
    write_regs(1'b1, 13'd4, 1'b1, 13'd3);
    send_run(12);

    // Random phases; the first one runs at the widest size
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_ITEMS) begin
      settle();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 9);
      if (phase == 0) kind = PH_WIDE_PART;
      else if (pick == 8 && sb.at_frame_start()) kind = PH_WIDE_PART;
      else if (pick == 9) kind = PH_TALL;
      else if (pick >= 6) kind = PH_PARTIAL;
      else kind = PH_FRAMES;

      // Widen only at a frame start so no unwritten store entry gets read
      raw_w = small_dim(10);
      if (!sb.at_frame_start() && sb.sat_dim(32'(raw_w), MAX_WIDTH) > sb.eff_width())
        raw_w = CFG_W'(sb.eff_width());
      raw_h = small_dim(8);

      case (kind)
        PH_WIDE_PART: begin
          if ($urandom_range(0, 1) != 0) raw_w = CFG_W'(MAX_WIDTH);
          else raw_w = CFG_W'($urandom_range(MAX_WIDTH + 1, CFG_MAX));
          write_regs(1'b1, raw_w, 1'b1, raw_h);
          n = $urandom_range(1, 100);
        end
        PH_TALL: begin
          write_regs(1'b1, raw_w, 1'b1, CFG_W'($urandom_range(HEIGHT_LIMIT, CFG_MAX)));
          w = sb.eff_width();
          n = w * $urandom_range(3, 6) + $urandom_range(0, w - 1);
        end
        PH_PARTIAL: begin
          write_regs(1'b1, raw_w, 1'($urandom_range(0, 1)), raw_h);
          n = $urandom_range(1, 3 * sb.eff_width());
        end
        default: begin
          write_regs(1'b1, raw_w, 1'b1, raw_h);
          w = sb.eff_width();
          h = sb.eff_height();
          n = sb.to_frame_end() + $urandom_range(0, 2) * w * h;
        end
      endcase
      send_run(n);
      rand_sent += n;
      phase++;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/cks_pkg.sv
design/cks_lane.sv
design/cks_line_store.sv
design/cks_out_queue.sv
design/cross_kernel_sharpen_3x3.sv
tb/sv/testbench.sv
